### rtl/gbm_pkg.sv
// Shared types, codes and constants of the GF(2) bit matrix engine.
package gbm_pkg;

  localparam int MAX_ROWS_DEF       = 64;
  localparam int MAX_COLUMNS_DEF    = 256;
  localparam int WORDS_PER_LINE_DEF = 8;

  localparam logic [31:0] HASH_PRIME = 32'h0100_0193;
  localparam logic [31:0] LOW_HALF   = 32'hFFFF_FFFF;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;

  typedef enum logic [3:0] {
    CMD_TEST     = 4'd0,
    CMD_SET      = 4'd1,
    CMD_CLEAR    = 4'd2,
    CMD_FLIP     = 4'd3,
    CMD_SWAP     = 4'd4,
    CMD_ADDROW   = 4'd5,
    CMD_FIRSTSET = 4'd6,
    CMD_WEIGHT   = 4'd7,
    CMD_RESET    = 4'd8,
    CMD_FOLD     = 4'd9
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MAP_A, S_MAP_B, S_DISP, S_BIT_RD, S_BIT_WB, S_SWAP_A, S_SWAP_B,
    S_ADD_RS, S_ADD_RD, S_ADD_WR, S_FS_RD, S_FS_CHK, S_WT_RD, S_WT_ACC,
    S_CLR_RD, S_CLR_WR, S_FD_MAP, S_FD_MAPQ, S_FD_RD, S_FD_LO, S_FD_HI, S_DONE
  } state_t;

  // Control signals of the word store in the current cycle.
  typedef struct packed {
    logic rd_en;
    logic rd_pad;
    logic wr_en;
    logic clr_all;
    logic clr_row;
  } st_ctl_t;

  // Index of the lowest set bit, found byte by byte.
  function automatic logic [5:0] first_one(input logic [63:0] v);
    logic [2:0] byte_sel;
    logic [2:0] bit_sel;
    logic       hit;
    logic [7:0] sel_byte;
    byte_sel = '0;
    bit_sel  = '0;
    hit      = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (!hit && (v[b*8 +: 8] != 8'd0)) begin
        byte_sel = 3'(b);
        hit      = 1'b1;
      end
    end
    sel_byte = v[byte_sel*8 +: 8];
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!hit && sel_byte[k]) begin
        bit_sel = 3'(k);
        hit     = 1'b1;
      end
    end
    return {byte_sel, bit_sel};
  endfunction

  function automatic logic [6:0] pop_count(input logic [63:0] v);
    logic [6:0] sum;
    sum = '0;
    for (int b = 0; b < 64; b++) begin
      sum = sum + 7'(v[b]);
    end
    return sum;
  endfunction

endpackage

### rtl/gf2_bit_matrix_engine.sv
// Top level of the GF(2) bit matrix engine: command sequencer, row map and hash datapath.
//
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_cmd, in_row_a, in_row_b, in_column, in_seed
// out_      output     out_valid / out_ready  out_bit_value, out_found_column,
//                                             out_row_weight, out_hash
// cfg_      input      cfg_we                 cfg_index, cfg_data
//
// One command is worked on at a time; each transaction gives exactly one result.
// Bit commands and a swap read the map twice, then do the word read-modify-write or
// the two map writes. Add-row reads the source word, reads the target word and writes
// it back for each stored word; weight and first-set read a word and then use it, one
// store port being shared by all reads. Reset reads the row map and clears the row,
// row by row; fold reads each row's map entry and then every word of its padded line,
// and every half word passes the multiplier.
// A low rst_n, and a write to either size register, clears the row map and the store
// through valid bits. A result waiting at the output does not stop the next
// transaction from being accepted; only its completion waits for the output register.
module gf2_bit_matrix_engine
  import gbm_pkg::*;
#(
  parameter int MAX_ROWS       = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS    = MAX_COLUMNS_DEF,
  parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_cmd,
  input  logic [5:0]  in_row_a,
  input  logic [5:0]  in_row_b,
  input  logic [7:0]  in_column,
  input  logic [31:0] in_seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_bit_value,
  output logic [8:0]  out_found_column,
  output logic [8:0]  out_row_weight,
  output logic [31:0] out_hash
);

  localparam int STORE_WORDS = (MAX_COLUMNS + 63) / 64;
  localparam int STORE_DEPTH = MAX_ROWS * STORE_WORDS;
  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW  = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  // The word counter must reach both the stored words and a padded line.
  localparam int WCW = $clog2(STORE_WORDS + WORDS_PER_LINE + 16) + 1;

  // Configuration registers and their effective values.
  logic [6:0] cfg_rows_r;
  logic [8:0] cfg_cols_r;
  logic [6:0] rows_eff;
  logic [8:0] cols_eff;
  logic       cfg_hit;

  assign rows_eff = (32'(cfg_rows_r) > MAX_ROWS)    ? 7'(MAX_ROWS)    : cfg_rows_r;
  assign cols_eff = (32'(cfg_cols_r) > MAX_COLUMNS) ? 9'(MAX_COLUMNS) : cfg_cols_r;
  assign cfg_hit  = cfg_we && ((cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= 7'd64;
      cfg_cols_r <= 9'd256;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROWS) begin
        cfg_rows_r <= cfg_data[6:0];
      end else if (cfg_index == CFG_COLS) begin
        cfg_cols_r <= cfg_data;
      end
    end
  end

  state_t state_r, state_nxt;

  // Latched command and its working registers.
  cmd_t            cmd_r;
  logic [5:0]      row_a_r, row_b_r;
  logic [7:0]      col_r;
  logic [PW-1:0]   pa_r, pb_r, pi_r;
  logic [WCW-1:0]  w_r;
  logic [KW-1:0]   k_r;
  logic [6:0]      i_r;
  logic            first_r;
  logic [63:0]     src_r;
  logic [63:0]     wd_r;
  logic [31:0]     h_r;
  logic            res_bit_r;
  logic [8:0]      res_found_r;
  logic [8:0]      res_weight_r;

  logic            out_valid_r;
  logic            out_bit_r;
  logic [8:0]      out_found_r, out_weight_r;
  logic [31:0]     out_hash_r;

  logic accept;
  logic done_go;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign done_go  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Range checks on the incoming command.
  logic in_a, in_b, in_col, ok_in;
  assign in_a   = {1'b0, in_row_a} < rows_eff;
  assign in_b   = {1'b0, in_row_b} < rows_eff;
  assign in_col = {1'b0, in_column} < cols_eff;

  always_comb begin
    unique case (in_cmd)
      CMD_TEST, CMD_SET, CMD_CLEAR, CMD_FLIP, CMD_FIRSTSET: ok_in = in_a && in_col;
      CMD_SWAP:   ok_in = in_a && in_b && (in_row_a != in_row_b);
      CMD_ADDROW: ok_in = in_a && in_b;
      CMD_WEIGHT: ok_in = in_a;
      CMD_RESET, CMD_FOLD: ok_in = (rows_eff != 7'd0);
      default:    ok_in = 1'b0;
    endcase
  end

  // Row map memory with per-entry valid bits; an entry never written holds its index.
  logic [PW-1:0]    map_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] map_valid_r;
  logic             mp_re, mp_we;
  logic [PW-1:0]    mp_ra, mp_wa, mp_wd;
  logic [PW-1:0]    mp_q_r, mp_qa_r;
  logic             mp_qv_r;
  logic [PW-1:0]    mp_eff;

  always_ff @(posedge clk) begin
    if (mp_we) begin
      map_mem[mp_wa] <= mp_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mp_re) begin
      mp_q_r  <= map_mem[mp_ra];
      mp_qa_r <= mp_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      map_valid_r <= '0;
      mp_qv_r     <= 1'b0;
    end else begin
      if (mp_re) begin
        mp_qv_r <= map_valid_r[mp_ra];
      end
      if (mp_we) begin
        map_valid_r[mp_wa] <= 1'b1;
      end
    end
  end

  assign mp_eff = mp_qv_r ? mp_q_r : mp_qa_r;

  // Word store.
  st_ctl_t        st_ctl;
  logic [AW-1:0]  st_ra, st_wa;
  logic [63:0]    st_wd;
  logic [PW-1:0]  st_clr_phys;
  logic [63:0]    rd_word;

  gbm_store #(
    .ROWS  (MAX_ROWS),
    .WORDS (STORE_WORDS),
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .PW    (PW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (st_ctl),
    .rd_addr  (st_ra),
    .wr_addr  (st_wa),
    .wr_data  (st_wd),
    .clr_phys (st_clr_phys),
    .rd_word  (rd_word)
  );

  // Derived loop bounds and per-word values.
  logic [WCW-1:0] last_word;
  logic [WCW-1:0] line_need;
  logic [WCW-1:0] col_word;
  logic [9:0]     cols_m1;
  logic [9:0]     cols_p63;
  logic           word_last;
  logic           fold_last;
  logic [63:0]    bit_mask;
  logic [63:0]    fs_word;
  logic [12:0]    fs_col;
  logic [31:0]    mix_lo, mix_hi;

  assign cols_m1   = {1'b0, cols_eff} - 10'd1;
  assign cols_p63  = {1'b0, cols_eff} + 10'd63;
  assign last_word = WCW'(cols_m1 >> 6);
  assign line_need = WCW'(cols_p63 >> 6);
  assign col_word  = WCW'(col_r >> 6);
  assign word_last = (w_r == WCW'(STORE_WORDS - 1));
  // A line ends on a multiple of its length once every needed word is covered.
  assign fold_last = (k_r == KW'(WORDS_PER_LINE - 1)) && ((w_r + WCW'(1)) >= line_need);
  assign bit_mask  = 64'd1 << col_r[5:0];
  assign fs_word   = first_r ? (rd_word & ~(bit_mask - 64'd1)) : rd_word;
  assign fs_col    = (13'(w_r) << 6) + 13'(first_one(fs_word));
  assign mix_lo    = 32'((h_r ^ rd_word[31:0]) * HASH_PRIME);
  assign mix_hi    = 32'((h_r ^ wd_r[63:32]) * HASH_PRIME);

  function automatic logic [AW-1:0] word_addr(input logic [PW-1:0] p,
                                              input logic [WCW-1:0] w);
    return AW'(int'(p) * STORE_WORDS + int'(w));
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!ok_in) begin
            state_nxt = S_DONE;
          end else if (in_cmd == CMD_RESET) begin
            state_nxt = S_CLR_RD;
          end else if (in_cmd == CMD_FOLD) begin
            state_nxt = S_FD_MAP;
          end else begin
            state_nxt = S_MAP_A;
          end
        end
      end
      S_MAP_A: state_nxt = S_MAP_B;
      S_MAP_B: state_nxt = S_DISP;
      S_DISP: begin
        unique case (cmd_r)
          CMD_SWAP:     state_nxt = S_SWAP_A;
          CMD_ADDROW:   state_nxt = S_ADD_RS;
          CMD_FIRSTSET: state_nxt = S_FS_RD;
          CMD_WEIGHT:   state_nxt = S_WT_RD;
          default:      state_nxt = S_BIT_RD;
        endcase
      end
      S_BIT_RD: state_nxt = S_BIT_WB;
      S_BIT_WB: state_nxt = S_DONE;
      S_SWAP_A: state_nxt = S_SWAP_B;
      S_SWAP_B: state_nxt = S_DONE;
      S_ADD_RS: state_nxt = S_ADD_RD;
      S_ADD_RD: state_nxt = S_ADD_WR;
      S_ADD_WR: state_nxt = word_last ? S_DONE : S_ADD_RS;
      S_FS_RD:  state_nxt = S_FS_CHK;
      S_FS_CHK: state_nxt = ((fs_word != 64'd0) || (w_r >= last_word)) ? S_DONE : S_FS_RD;
      S_WT_RD:  state_nxt = S_WT_ACC;
      S_WT_ACC: state_nxt = word_last ? S_DONE : S_WT_RD;
      S_CLR_RD: state_nxt = S_CLR_WR;
      S_CLR_WR: state_nxt = (i_r == rows_eff - 7'd1) ? S_DONE : S_CLR_RD;
      S_FD_MAP:  state_nxt = S_FD_MAPQ;
      S_FD_MAPQ: state_nxt = S_FD_RD;
      S_FD_RD:   state_nxt = S_FD_LO;
      S_FD_LO:   state_nxt = S_FD_HI;
      S_FD_HI: begin
        if (!fold_last) begin
          state_nxt = S_FD_RD;
        end else if (i_r == rows_eff - 7'd1) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FD_MAP;
        end
      end
      S_DONE:  state_nxt = done_go ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    mp_re       = 1'b0;
    mp_we       = 1'b0;
    mp_ra       = PW'(row_a_r);
    mp_wa       = PW'(row_a_r);
    mp_wd       = pb_r;
    st_ctl      = '0;
    st_ctl.clr_all = cfg_hit;
    st_ra       = word_addr(pa_r, w_r);
    st_wa       = word_addr(pa_r, w_r);
    st_wd       = rd_word ^ src_r;
    st_clr_phys = mp_eff;
    unique case (state_r)
      S_MAP_A: mp_re = 1'b1;
      S_MAP_B: begin
        mp_re = 1'b1;
        mp_ra = PW'(row_b_r);
      end
      S_BIT_RD: begin
        st_ctl.rd_en = 1'b1;
        st_ra        = word_addr(pa_r, col_word);
      end
      S_BIT_WB: begin
        st_wa = word_addr(pa_r, col_word);
        unique case (cmd_r)
          CMD_SET:   st_wd = rd_word | bit_mask;
          CMD_CLEAR: st_wd = rd_word & ~bit_mask;
          default:   st_wd = rd_word ^ bit_mask;
        endcase
        st_ctl.wr_en = (cmd_r != CMD_TEST);
      end
      S_SWAP_A: mp_we = 1'b1;
      S_SWAP_B: begin
        mp_we = 1'b1;
        mp_wa = PW'(row_b_r);
        mp_wd = pa_r;
      end
      S_ADD_RS: begin
        st_ctl.rd_en = 1'b1;
        st_ra        = word_addr(pb_r, w_r);
      end
      S_ADD_RD: st_ctl.rd_en = 1'b1;
      S_ADD_WR: st_ctl.wr_en = 1'b1;
      S_FS_RD:  st_ctl.rd_en = 1'b1;
      S_WT_RD:  st_ctl.rd_en = 1'b1;
      S_CLR_RD: begin
        mp_re = 1'b1;
        mp_ra = PW'(i_r);
      end
      S_CLR_WR: st_ctl.clr_row = 1'b1;
      S_FD_MAP: begin
        mp_re = 1'b1;
        mp_ra = PW'(i_r);
      end
      S_FD_RD: begin
        st_ctl.rd_en  = 1'b1;
        st_ctl.rd_pad = (w_r >= WCW'(STORE_WORDS));
        st_ra         = word_addr(pi_r, w_r);
      end
      default: ;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_r        <= cmd_t'(in_cmd);
          row_a_r      <= in_row_a;
          row_b_r      <= in_row_b;
          col_r        <= in_column;
          h_r          <= in_seed;
          i_r          <= 7'd0;
          res_bit_r    <= 1'b0;
          res_weight_r <= 9'd0;
          res_found_r  <= (in_cmd == CMD_FIRSTSET) ? cols_eff : 9'd0;
        end
      end
      S_MAP_B: pa_r <= mp_eff;
      S_DISP: begin
        pb_r    <= mp_eff;
        w_r     <= (cmd_r == CMD_FIRSTSET) ? col_word : WCW'(0);
        first_r <= 1'b1;
      end
      S_BIT_WB: res_bit_r <= (cmd_r == CMD_TEST) && rd_word[col_r[5:0]];
      S_ADD_RD: src_r <= rd_word;
      S_ADD_WR: w_r <= w_r + WCW'(1);
      S_FS_CHK: begin
        if (fs_word != 64'd0) begin
          res_found_r <= (fs_col < 13'(cols_eff)) ? 9'(fs_col) : cols_eff;
        end
        w_r     <= w_r + WCW'(1);
        first_r <= 1'b0;
      end
      S_WT_ACC: begin
        res_weight_r <= res_weight_r + 9'(pop_count(rd_word));
        w_r          <= w_r + WCW'(1);
      end
      S_CLR_WR: i_r <= i_r + 7'd1;
      S_FD_MAP: begin
        w_r <= '0;
        k_r <= '0;
      end
      S_FD_MAPQ: pi_r <= mp_eff;
      S_FD_LO: begin
        wd_r <= rd_word;
        h_r  <= mix_lo;
      end
      S_FD_HI: begin
        h_r <= mix_hi;
        w_r <= w_r + WCW'(1);
        k_r <= (k_r == KW'(WORDS_PER_LINE - 1)) ? KW'(0) : k_r + KW'(1);
        if (fold_last) begin
          i_r <= i_r + 7'd1;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_bit_r    <= res_bit_r;
      out_found_r  <= res_found_r;
      out_weight_r <= res_weight_r;
      // A fold over no rows answers the seed, which the hash register already holds.
      out_hash_r   <= (cmd_r == CMD_FOLD) ? h_r : 32'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bit_value    = out_bit_r;
  assign out_found_column = out_found_r;
  assign out_row_weight   = out_weight_r;
  assign out_hash         = out_hash_r;

endmodule

### rtl/gbm_store.sv
// Word store of the bit matrix: synchronous memory with registered read and per-word valid bits.
module gbm_store
  import gbm_pkg::*;
#(
  parameter int ROWS  = MAX_ROWS_DEF,
  parameter int WORDS = (MAX_COLUMNS_DEF + 63) / 64,
  parameter int DEPTH = ROWS * WORDS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int PW    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  st_ctl_t       ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic [PW-1:0] clr_phys,
  output logic [63:0]   rd_word
);

  logic [63:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [63:0]      q_r;
  logic             qv_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // An entry never written since the last clear, and any padded read, reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      valid_r <= '0;
      qv_r    <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        qv_r <= valid_r[rd_addr] && !ctl.rd_pad;
      end
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.clr_row) begin
        for (int r = 0; r < ROWS; r++) begin
          for (int k = 0; k < WORDS; k++) begin
            if (clr_phys == PW'(r)) begin
              valid_r[r*WORDS + k] <= 1'b0;
            end
          end
        end
      end
    end
  end

  assign rd_word = qv_r ? q_r : 64'd0;

endmodule

### bench/tb_top.sv
// Self-checking testbench for the GF(2) bit matrix engine top level.
`timescale 1ns / 1ps

module tb_top
  import gbm_pkg::*;
();

  // Result of one command, as the output port presents it.
  typedef struct {
    logic        bit_value;
    logic [8:0]  found_column;
    logic [8:0]  row_weight;
    logic [31:0] hash;
  } matrix_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ROWS;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_cmd = CMD_TEST;
  logic [5:0]  in_row_a = '0;
  logic [5:0]  in_row_b = '0;
  logic [7:0]  in_column = '0;
  logic [31:0] in_seed = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_bit_value;
  logic [8:0]  out_found_column;
  logic [8:0]  out_row_weight;
  logic [31:0] out_hash;

  // Shadow copy of the matrix: stored words per physical row, the logical row map
  // and the two size registers exactly as written.
  logic [63:0] shadow_words [64][4];
  logic [5:0]  shadow_map [64];
  logic [6:0]  shadow_rows;
  logic [8:0]  shadow_cols;

  matrix_result_t pending_results [$];
  int          error_count = 0;
  bit          no_idle = 1'b0;

  always #5 clk = ~clk;

  gf2_bit_matrix_engine uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_row_a         (in_row_a),
    .in_row_b         (in_row_b),
    .in_column        (in_column),
    .in_seed          (in_seed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bit_value    (out_bit_value),
    .out_found_column (out_found_column),
    .out_row_weight   (out_row_weight),
    .out_hash         (out_hash)
  );

  // Building a new matrix: every bit cleared and the row map back to identity.
  function automatic void clear_shadow();
    for (int r = 0; r < 64; r++) begin
      shadow_map[r] = 6'(r);
      for (int w = 0; w < 4; w++) begin
        shadow_words[r][w] = '0;
      end
    end
  endfunction

  // Applies one command to the shadow matrix and returns the result it must give.
  function automatic matrix_result_t apply_command(logic [3:0] cmd, logic [5:0] ra,
                                                   logic [5:0] rb, logic [7:0] col,
                                                   logic [31:0] seed);
    matrix_result_t res;
    int          rows;
    int          cols;
    bit          a_ok;
    bit          col_ok;
    logic [5:0]  pa;
    logic [5:0]  pb;
    logic [5:0]  tmp;
    logic [63:0] v;
    logic [31:0] h;
    res = '{1'b0, 9'd0, 9'd0, 32'd0};
    // Registers above their bound act as the largest size.
    rows   = (shadow_rows > 64) ? 64 : int'(shadow_rows);
    cols   = (shadow_cols > 256) ? 256 : int'(shadow_cols);
    a_ok   = int'(ra) < rows;
    col_ok = int'(col) < cols;
    pa     = shadow_map[ra];
    pb     = shadow_map[rb];
    case (cmd)
      CMD_TEST, CMD_SET, CMD_CLEAR, CMD_FLIP: begin
        if (a_ok && col_ok) begin
          case (cmd)
            CMD_TEST:  res.bit_value = shadow_words[pa][col[7:6]][col[5:0]];
            CMD_SET:   shadow_words[pa][col[7:6]][col[5:0]] = 1'b1;
            CMD_CLEAR: shadow_words[pa][col[7:6]][col[5:0]] = 1'b0;
            default:   shadow_words[pa][col[7:6]][col[5:0]] ^= 1'b1;
          endcase
        end
      end
      CMD_SWAP: begin
        if (a_ok && int'(rb) < rows && ra != rb) begin
          tmp            = shadow_map[ra];
          shadow_map[ra] = shadow_map[rb];
          shadow_map[rb] = tmp;
        end
      end
      CMD_ADDROW: begin
        if (a_ok && int'(rb) < rows) begin
          for (int w = 0; w < 4; w++) begin
            shadow_words[pa][w] ^= shadow_words[pb][w];
          end
        end
      end
      CMD_FIRSTSET: begin
        // A set bit beyond the columns in use does not count.
        res.found_column = 9'(cols);
        if (a_ok && col_ok) begin
          for (int c = int'(col); c < cols; c++) begin
            if (shadow_words[pa][c / 64][c % 64]) begin
              res.found_column = 9'(c);
              break;
            end
          end
        end
      end
      CMD_WEIGHT: begin
        if (a_ok) begin
          for (int c = 0; c < 256; c++) begin
            res.row_weight += 9'(shadow_words[pa][c / 64][c % 64]);
          end
        end
      end
      CMD_RESET: begin
        for (int r = 0; r < rows; r++) begin
          for (int w = 0; w < 4; w++) begin
            shadow_words[shadow_map[r]][w] = '0;
          end
        end
      end
      CMD_FOLD: begin
        // A line is always eight words at these sizes; the top four are padding.
        h = seed;
        for (int r = 0; r < rows; r++) begin
          for (int w = 0; w < 8; w++) begin
            v = (w < 4) ? shadow_words[shadow_map[r]][w] : 64'd0;
            h = (h ^ v[31:0]) * HASH_PRIME;
            h = (h ^ v[63:32]) * HASH_PRIME;
          end
        end
        res.hash = h;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Sends one command. The valid is left high after the transaction so that a
  // following command with no gap keeps it high; settle_engine lowers it.
  task automatic send_command(logic [3:0] cmd, logic [5:0] ra, logic [5:0] rb,
                              logic [7:0] col, logic [31:0] seed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_row_a  <= ra;
    in_row_b  <= rb;
    in_column <= col;
    in_seed   <= seed;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_results.push_back(apply_command(cmd, ra, rb, col, seed));
  endtask

  // Lowers the input valid and waits until every expected result has come back
  // and the sequencer is certainly idle.
  task automatic settle_engine();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Writes one size register; the caller lowers the write enable afterwards.
  task automatic write_size(logic [1:0] idx, logic [8:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_ROWS) begin
      shadow_rows = value[6:0];
    end else begin
      shadow_cols = value;
    end
    clear_shadow();
  endtask

  task automatic set_sizes(logic [8:0] rows, logic [8:0] cols);
    settle_engine();
    write_size(CFG_ROWS, rows);
    write_size(CFG_COLS, cols);
    cfg_we <= 1'b0;
  endtask

  // Corner cases at the reset sizes: edges of the matrix, every command, equal
  // swap, empty search, and the undefined command codes.
  task automatic test_directed();
    send_command(CMD_SET, 6'd0, 6'd0, 8'd0, '0);
    send_command(CMD_SET, 6'd63, 6'd0, 8'd255, '0);
    send_command(CMD_TEST, 6'd63, 6'd0, 8'd255, '0);
    send_command(CMD_TEST, 6'd63, 6'd0, 8'd254, '0);
    send_command(CMD_FLIP, 6'd0, 6'd0, 8'd129, '0);
    send_command(CMD_SWAP, 6'd0, 6'd63, 8'd0, '0);
    send_command(CMD_SWAP, 6'd5, 6'd5, 8'd0, '0);
    send_command(CMD_ADDROW, 6'd0, 6'd63, 8'd0, '0);
    send_command(CMD_FIRSTSET, 6'd0, 6'd0, 8'd1, '0);
    send_command(CMD_FIRSTSET, 6'd63, 6'd0, 8'd130, '0);
    send_command(CMD_FIRSTSET, 6'd20, 6'd0, 8'd0, '0);
    send_command(CMD_WEIGHT, 6'd0, 6'd0, 8'd0, '0);
    send_command(CMD_CLEAR, 6'd63, 6'd0, 8'd0, '0);
    send_command(CMD_FOLD, 6'd0, 6'd0, 8'd0, 32'hFFFF_FFFF);
    for (int c = CMD_FOLD + 1; c < 16; c++) begin
      send_command(4'(c), 6'h3F, 6'h3F, 8'hFF, 32'hFFFF_FFFF);
    end
    send_command(CMD_RESET, 6'd0, 6'd0, 8'd0, '0);
    send_command(CMD_WEIGHT, 6'd63, 6'd0, 8'd0, '0);
  endtask

  // Size registers at and beyond their bounds, with commands that address the
  // edge of the matrix on both sides of it.
  task automatic test_sizes();
    logic [8:0] rows_list [6] = '{9'd0, 9'd127, 9'd1, 9'd64, 9'd5, 9'd3};
    logic [8:0] cols_list [6] = '{9'd0, 9'd511, 9'd1, 9'd256, 9'd70, 9'd200};
    for (int s = 0; s < 6; s++) begin
      set_sizes(rows_list[s], cols_list[s]);
      send_command(CMD_SET, 6'd0, 6'd0, 8'd0, '0);
      send_command(CMD_SET, 6'(rows_list[s] - 1), 6'd0, 8'(cols_list[s] - 1), '0);
      send_command(CMD_SET, 6'(rows_list[s]), 6'd0, 8'(cols_list[s]), '0);
      send_command(CMD_TEST, 6'(rows_list[s] - 1), 6'd0, 8'(cols_list[s] - 1), '0);
      send_command(CMD_SWAP, 6'd0, 6'(rows_list[s]), 8'd0, '0);
      send_command(CMD_ADDROW, 6'(rows_list[s]), 6'd0, 8'd0, '0);
      send_command(CMD_FIRSTSET, 6'd0, 6'd0, 8'd1, '0);
      send_command(CMD_FIRSTSET, 6'd0, 6'd0, 8'(cols_list[s]), '0);
      send_command(CMD_WEIGHT, 6'(rows_list[s]), 6'd0, 8'd0, '0);
      send_command(CMD_FOLD, 6'd0, 6'd0, 8'd0, $urandom);
    end
  endtask

  // Random phases, each under fresh sizes. Most commands build up and rearrange
  // rows inside the matrix; a few stray outside it or use undefined codes.
  task automatic test_random();
    logic [3:0] cmd;
    logic [5:0] ra;
    logic [5:0] rb;
    logic [7:0] col;
    int         pick;
    int         rows;
    int         cols;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0:       set_sizes(9'($urandom_range(1, 8)), 9'($urandom_range(1, 511)));
        1:       set_sizes(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        default: set_sizes(9'($urandom_range(1, 64)), 9'($urandom_range(64, 256)));
      endcase
      rows = (shadow_rows > 64) ? 64 : int'(shadow_rows);
      cols = (shadow_cols > 256) ? 256 : int'(shadow_cols);
      no_idle = (phase % 3 == 2);
      for (int n = 0; n < 95; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          cmd = (pick < 20) ? CMD_SET : CMD_FLIP;
        end else if (pick < 40) begin
          cmd = CMD_TEST;
        end else if (pick < 45) begin
          cmd = CMD_CLEAR;
        end else if (pick < 53) begin
          cmd = CMD_SWAP;
        end else if (pick < 63) begin
          cmd = CMD_ADDROW;
        end else if (pick < 76) begin
          cmd = CMD_FIRSTSET;
        end else if (pick < 86) begin
          cmd = CMD_WEIGHT;
        end else if (pick < 88) begin
          cmd = CMD_RESET;
        end else if (pick < 94) begin
          cmd = CMD_FOLD;
        end else if (pick < 96) begin
          cmd = 4'($urandom_range(CMD_FOLD + 1, 15));
        end else begin
          cmd = 4'($urandom_range(0, 15));
        end
        // One draw in eight, and every draw when there are no rows, is allowed anywhere in the field's range.
        if ($urandom_range(0, 7) == 0 || rows == 0) begin
          ra  = 6'($urandom);
          rb  = 6'($urandom);
          col = 8'($urandom);
        end else begin
          ra  = 6'($urandom_range(0, rows - 1));
          rb  = 6'($urandom_range(0, rows - 1));
          col = (cols == 0) ? 8'($urandom) : 8'($urandom_range(0, cols - 1));
        end
        send_command(cmd, ra, rb, col, $urandom);
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: random back-pressure, then each result against the oldest
  // expectation.
  initial begin : result_check
    int             stall;
    matrix_result_t exp_res;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, bit %b found %0d weight %0d hash %h",
                 $time, out_bit_value, out_found_column, out_row_weight, out_hash);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_bit_value !== exp_res.bit_value) begin
          $display("%0t: bit_value expected %b, got %b",
                   $time, exp_res.bit_value, out_bit_value);
          error_count++;
        end
        if (out_found_column !== exp_res.found_column) begin
          $display("%0t: found_column expected %0d, got %0d",
                   $time, exp_res.found_column, out_found_column);
          error_count++;
        end
        if (out_row_weight !== exp_res.row_weight) begin
          $display("%0t: row_weight expected %0d, got %0d",
                   $time, exp_res.row_weight, out_row_weight);
          error_count++;
        end
        if (out_hash !== exp_res.hash) begin
          $display("%0t: hash expected %h, got %h", $time, exp_res.hash, out_hash);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    shadow_rows = 7'd64;
    shadow_cols = 9'd256;
    clear_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sizes();
    test_random();
    settle_engine();
    if (pending_results.size() != 0) begin
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run, where every command is a
  // full-size fold under the longest stalls.
  initial begin : watchdog
    #60ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
